### rtl/core/psd_pkg.sv
package psd_pkg;

  localparam int PHASE_W   = 16;
  localparam int GEOM_W    = 10;
  localparam int POS_W     = 9;
  localparam int CHG_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  localparam logic [GEOM_W-1:0] GEOM_MIN   = 10'd3;
  localparam int                GEOM_RESET = 512;

  // ring TL T TR R BR B BL L TL over the row-major 3x3 window
  localparam logic [3:0] RING [9] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3, 4'd0};

endpackage

### rtl/core/psd_ifs.sv
interface psd_pix_if;
  import psd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] phase;
  modport source (output valid, output phase, input ready);
  modport sink (input valid, input phase, output ready);
endinterface

interface psd_res_if;
  import psd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    window_valid;
  logic [POS_W-1:0]        center_row;
  logic [POS_W-1:0]        center_col;
  logic signed [CHG_W-1:0] charge;
  logic                    singular_now;
  logic                    singular_ever;
  modport source (output valid, output window_valid, output center_row, output center_col,
                  output charge, output singular_now, output singular_ever, input ready);
  modport sink (input valid, input window_valid, input center_row, input center_col,
                input charge, input singular_now, input singular_ever, output ready);
endinterface

interface psd_cfg_if;
  import psd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GEOM_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/phase_singularity_detector.sv
// Pipeline: an accepted pixel request moves through stages 0 to 3 and the output register to its result.
// Throughput: one pixel per cycle while the output is not stalled; line stores and history store are read-modify-write
// memories with registered reads, one access per port per cycle.
// Reset: async, active low. After reset a clearing pass zeroes the line stores and the history
// store; pixel ready stays low meanwhile.
module phase_singularity_detector
  import psd_pkg::*;
#(
  parameter int MAX_COLS   = 512,
  parameter int MAX_ROWS   = 512,
  parameter int ANGLE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psd_pix_if.sink   in_chan,
  psd_res_if.source out_chan,
  psd_cfg_if.sink   cfg_chan
);

  localparam int AB       = ANGLE_BITS;
  localparam int CW       = $clog2(MAX_COLS);
  localparam int RW       = $clog2(MAX_ROWS);
  localparam int GCW      = $clog2(MAX_COLS + 1);
  localparam int GRW      = $clog2(MAX_ROWS + 1);
  localparam int CLR_N    = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int CLW      = $clog2(CLR_N);
  localparam int SW       = AB + 3;
  localparam int COLS_RST = (MAX_COLS < GEOM_RESET) ? MAX_COLS : GEOM_RESET;
  localparam int ROWS_RST = (MAX_ROWS < GEOM_RESET) ? MAX_ROWS : GEOM_RESET;

  // geometry registers
  logic [GCW-1:0] cols_q, cols_cl;
  logic [GRW-1:0] rows_q, rows_cl;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    if (cfg_chan.data < GEOM_MIN) begin
      cols_cl = GCW'(GEOM_MIN);
    end else if (32'(cfg_chan.data) > 32'(MAX_COLS)) begin
      cols_cl = GCW'(MAX_COLS);
    end else begin
      cols_cl = GCW'(cfg_chan.data);
    end
    if (cfg_chan.data < GEOM_MIN) begin
      rows_cl = GRW'(GEOM_MIN);
    end else if (32'(cfg_chan.data) > 32'(MAX_ROWS)) begin
      rows_cl = GRW'(MAX_ROWS);
    end else begin
      rows_cl = GRW'(cfg_chan.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= GCW'(COLS_RST);
      rows_q <= GRW'(ROWS_RST);
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_COLS: cols_q <= cols_cl;
        REG_ROWS: rows_q <= rows_cl;
        default: ;
      endcase
    end
  end

  // clearing pass
  logic           clr_busy_q;
  logic [CLW-1:0] clr_cnt_q;
  logic           clr_line, clr_hist;

  assign clr_line = ({1'b0, clr_cnt_q} < (CLW + 1)'(MAX_COLS));
  assign clr_hist = ({1'b0, clr_cnt_q} < (CLW + 1)'(MAX_ROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == CLW'(CLR_N - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // handshake
  logic en, acc;
  logic out_valid_q;

  assign en            = !out_valid_q || out_chan.ready;
  assign in_chan.ready = en && !clr_busy_q;
  assign acc           = in_chan.valid && in_chan.ready;

  // stage 0: position and line store read
  logic [CW-1:0]  col_q, col_d, c_s0;
  logic [RW-1:0]  row_q, row_d, r_s0;
  logic [RW:0]    r_ext, r_inc;
  logic [GCW-1:0] c_inc;
  logic [39:0]    ph_ext;
  logic [AB-1:0]  a_s0;

  assign ph_ext = {in_chan.phase, 24'b0};
  assign a_s0   = ph_ext[39 -: AB];

  always_comb begin
    c_s0  = col_q;
    r_ext = (RW + 1)'(row_q);
    if (GCW'(col_q) >= cols_q) begin
      c_s0  = '0;
      r_ext = r_ext + 1'b1;
    end
    if (r_ext >= (RW + 1)'(rows_q)) begin
      r_ext = '0;
    end
    r_s0  = r_ext[RW-1:0];
    c_inc = GCW'(c_s0) + 1'b1;
    r_inc = (RW + 1)'(r_s0) + 1'b1;
    if (c_inc >= cols_q) begin
      col_d = '0;
      row_d = (r_inc >= (RW + 1)'(rows_q)) ? '0 : r_inc[RW-1:0];
    end else begin
      col_d = c_inc[CW-1:0];
      row_d = r_s0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  logic          v1_q;
  logic [AB-1:0] a1_q;
  logic [CW-1:0] c1_q;
  logic [RW-1:0] r1_q;

  logic [AB-1:0] line0_mem [MAX_COLS];
  logic [AB-1:0] line1_mem [MAX_COLS];
  logic [AB-1:0] l0_rd_q, l1_rd_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      l0_rd_q <= line0_mem[c_s0];
      l1_rd_q <= line1_mem[c_s0];
    end
    if (clr_busy_q) begin
      if (clr_line) begin
        line0_mem[clr_cnt_q[CW-1:0]] <= '0;
        line1_mem[clr_cnt_q[CW-1:0]] <= '0;
      end
    end else if (en && v1_q) begin
      line0_mem[c1_q] <= l1_rd_q;
      line1_mem[c1_q] <= a1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a1_q <= a_s0;
      c1_q <= c_s0;
      r1_q <= r_s0;
    end
  end

  // stage 1: window shift and history read
  logic [AB-1:0] win_q [9];
  logic [RW-1:0] cr1;
  logic [CW-1:0] cc1;
  logic          w1;

  assign cr1 = r1_q - 1'b1;
  assign cc1 = c1_q - 1'b1;
  assign w1  = (r1_q >= RW'(2)) && (c1_q >= CW'(2));

  always_ff @(posedge clk_i) begin
    if (en && v1_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= l0_rd_q;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= l1_rd_q;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= a1_q;
    end
  end

  logic [MAX_COLS-1:0] hist_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] hist_rd_q;

  logic          v2_q, w2_q;
  logic [RW-1:0] cr2_q;
  logic [CW-1:0] cc2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v1_q) begin
      w2_q  <= w1;
      cr2_q <= cr1;
      cc2_q <= cc1;
    end
  end

  // stage 2: wrapped ring differences, pair sums
  logic signed [AB-1:0] dif [8];
  logic signed [AB:0]   pair [4];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      dif[k] = $signed(AB'(win_q[RING[k+1]] - win_q[RING[k]]));
    end
    for (int k = 0; k < 4; k++) begin
      pair[k] = (AB + 1)'(dif[2*k]) + (AB + 1)'(dif[2*k+1]);
    end
  end

  logic               v3_q, w3_q, hb3_q;
  logic [RW-1:0]      cr3_q;
  logic [CW-1:0]      cc3_q;
  logic signed [AB:0] pair_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v2_q) begin
      w3_q   <= w2_q;
      cr3_q  <= cr2_q;
      cc3_q  <= cc2_q;
      hb3_q  <= hist_rd_q[cc2_q];
      pair_q <= pair;
    end
  end

  // stage 3: charge, history update
  logic signed [SW-1:0] sum;
  logic [CHG_W-1:0]     q3;
  logic                 now3, ever3;

  assign sum   = SW'(pair_q[0]) + SW'(pair_q[1]) + SW'(pair_q[2]) + SW'(pair_q[3]);
  assign q3    = sum[SW-1:AB];
  assign now3  = w3_q && (q3 != '0);
  assign ever3 = w3_q && (now3 || hb3_q);

  always_ff @(posedge clk_i) begin
    if (en && v1_q) begin
      hist_rd_q <= hist_mem[cr1];
    end
    if (clr_busy_q) begin
      if (clr_hist) begin
        hist_mem[clr_cnt_q[RW-1:0]] <= '0;
      end
    end else if (en && v3_q && now3) begin
      hist_mem[cr3_q][cc3_q] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v3_q) begin
      out_chan.window_valid  <= w3_q;
      out_chan.center_row    <= w3_q ? POS_W'(cr3_q) : '0;
      out_chan.center_col    <= w3_q ? POS_W'(cc3_q) : '0;
      out_chan.charge        <= w3_q ? $signed(q3) : '0;
      out_chan.singular_now  <= now3;
      out_chan.singular_ever <= ever3;
    end
  end

  assign out_chan.valid = out_valid_q;

endmodule

### rtl/core/psd_checker.sv
module psd_checker
  import psd_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    window_valid_i,
  input logic [POS_W-1:0]        center_row_i,
  input logic [POS_W-1:0]        center_col_i,
  input logic signed [CHG_W-1:0] charge_i,
  input logic                    singular_now_i,
  input logic                    singular_ever_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({window_valid_i, center_row_i, center_col_i, charge_i,
               singular_now_i, singular_ever_i}))
    else $error("result changed while stalled");

  a_now_charge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (singular_now_i == (window_valid_i && (charge_i != '0))))
    else $error("singular_now disagrees with charge");

  a_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !window_valid_i |-> (center_row_i == '0) && (center_col_i == '0) &&
      (charge_i == '0) && !singular_ever_i)
    else $error("border result carries nonzero fields");

  a_now_ever: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && singular_now_i |-> singular_ever_i)
    else $error("history flag missing for current singularity");

endmodule

bind phase_singularity_detector psd_checker u_psd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_chan.valid),
  .out_ready_i     (out_chan.ready),
  .window_valid_i  (out_chan.window_valid),
  .center_row_i    (out_chan.center_row),
  .center_col_i    (out_chan.center_col),
  .charge_i        (out_chan.charge),
  .singular_now_i  (out_chan.singular_now),
  .singular_ever_i (out_chan.singular_ever)
);
